@@ hw/rtl/dlid_pkg.sv @@
// ----------------------------------------------------------------------------
// dlid_pkg
// shared constants, types and helpers for the dual lock-in demodulator
// ----------------------------------------------------------------------------
package dlid_pkg;

  localparam int RefPeriodDef   = 8;
  localparam int SampleBitsDef  = 12;
  localparam int CoefFracDef    = 30;
  localparam int NumRegs        = 8;
  localparam int AddrBits       = 5;
  localparam int AccBits        = 72;

  localparam logic [31:0] RegReset [NumRegs] = '{
    32'sd16606802, 32'sd16606802, 32'sd1040528216, 32'sd1069343479,
    32'sd2141258160, -32'sd1067526902, 32'sd2144894387, -32'sd1071163148
  };

  localparam logic [31:0] PiQ29 = 32'd1686629713;

  // serial multiplier operation
  typedef struct packed {
    logic               start;
    logic signed [31:0] coef;
    logic signed [47:0] data;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [AccBits-1:0] prod;
  } mul_rsp_t;

  function automatic logic signed [15:0] ref_val(input logic [2:0] ix, input logic [1:0] mixer);
    logic signed [15:0] r;
    r = '0;
    unique case (mixer)
      2'd0: unique case (ix)
        3'd0, 3'd4: r = 16'sd0;
        3'd1, 3'd3: r = 16'sd11585;
        3'd2: r = 16'sd16384;
        3'd6: r = -16'sd16384;
        default: r = -16'sd11585;
      endcase
      2'd1: unique case (ix)
        3'd2, 3'd6: r = 16'sd0;
        3'd1, 3'd7: r = 16'sd11585;
        3'd0: r = 16'sd16384;
        3'd4: r = -16'sd16384;
        default: r = -16'sd11585;
      endcase
      2'd2: unique case (ix)
        3'd1, 3'd5: r = 16'sd16384;
        3'd3, 3'd7: r = -16'sd16384;
        default: r = 16'sd0;
      endcase
      default: unique case (ix)
        3'd0, 3'd4: r = 16'sd16384;
        3'd2, 3'd6: r = -16'sd16384;
        default: r = 16'sd0;
      endcase
    endcase
    return r;
  endfunction

  function automatic logic signed [47:0] sat32(input logic signed [AccBits-1:0] v);
    if (v > $signed({{(AccBits-32){1'b0}}, 32'h7fffffff})) return 48'sh0000_7fff_ffff;
    if (v < $signed({{(AccBits-32){1'b1}}, 32'h80000000})) return 48'shffff_8000_0000;
    return v[47:0];
  endfunction

endpackage

@@ hw/rtl/dlid_mul.sv @@
// ----------------------------------------------------------------------------
// dlid_mul
// bit-serial signed multiplier, 32-bit coefficient times 48-bit data
// ----------------------------------------------------------------------------
module dlid_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dlid_pkg::mul_req_t req_i,
  output dlid_pkg::mul_rsp_t rsp_o
);
  import dlid_pkg::*;

  logic [5:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic signed [AccBits-1:0] acc_q, acc_d;
  logic signed [AccBits-1:0] mcand_q, mcand_d;
  logic [31:0]               mplier_q, mplier_d;
  logic                      done_q, done_d;

  always_comb begin
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = '0;
      mcand_d  = AccBits'(req_i.data);
      mplier_d = req_i.coef;
    end else if (busy_q) begin
      // top bit of coefficient has negative weight
      if (mplier_q[0]) begin
        if (cnt_q == 6'd31) acc_d = acc_q - mcand_q;
        else acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

@@ hw/rtl/dual_lockin_demodulator_top.sv @@
// each result takes 24 passes through the one bit-serial 32x48 multiplier plus two
// 32-step square roots; the next item is taken once the result is registered,
// and a result still waiting holds the block in its last step
// reset: asynchronous active low, clears phase, filter delays, registers to defaults
// ----------------------------------------------------------------------------
// dual_lockin_demodulator_top
// lock-in i/q demodulator with low-pass, envelope and high-pass cascade
// ----------------------------------------------------------------------------
module dual_lockin_demodulator_top #(
  parameter int REF_PERIOD     = dlid_pkg::RefPeriodDef,
  parameter int SAMPLE_BITS    = dlid_pkg::SampleBitsDef,
  parameter int COEF_FRAC_BITS = dlid_pkg::CoefFracDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // detector_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // envelope_first, envelope_second, amplitude_first, amplitude_second, pad
  output logic [103:0]            m_axis_tdata_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [dlid_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import dlid_pkg::*;

  localparam int PhBits = $clog2(REF_PERIOD);

  typedef enum logic [3:0] {
    S_IDLE, S_LP, S_LPW, S_SQ, S_SQW, S_ROOT, S_PI, S_PIW,
    S_HP, S_HPW, S_OUT
  } state_e;

  state_e              state_q;
  logic [31:0]         cfg_q [NumRegs];
  logic [PhBits-1:0]   phase_q;
  logic signed [47:0]  lpd_q [4];
  logic signed [47:0]  hpd_q [8];
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [47:0]  y_q [4];
  logic [1:0]          mix_q;
  logic [2:0]          sub_q;
  logic signed [AccBits-1:0] t_q;
  logic                ch_q;
  logic [63:0]         sq_q, rem_q;
  logic [31:0]         root_q;
  logic [5:0]          it_q;
  logic [23:0]         env_q [2];
  logic signed [47:0]  hx_q, p_q, y1_q, y2_q;
  logic [24:0]         amp1_q;
  logic [103:0]        out_q;
  logic                ovalid_q;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  dlid_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  logic signed [47:0] mixv;
  logic signed [AccBits-1:0] rnd;
  assign mixv = 48'(x_q) * 48'(ref_val(3'(phase_q), mix_q));
  assign rnd  = (mrsp.prod + (AccBits'(1) <<< (COEF_FRAC_BITS-1))) >>> COEF_FRAC_BITS;

  assign pready = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = out_q;
  assign prdata = cfg_q[paddr[4:2]];

  // coefficient and data selection for the multiplier
  always_comb begin
    mreq = '0;
    mreq.start = (state_q == S_LP) || (state_q == S_PI) || (state_q == S_HP);
    unique case (state_q)
      S_LP: begin
        mreq.coef = cfg_q[sub_q[0] ? 1 : 0];
        mreq.data = mixv;
        if (sub_q == 3'd2) begin
          mreq.coef = cfg_q[2];
          mreq.data = y_q[mix_q];
        end
      end
      S_PI: begin
        mreq.coef = PiQ29;
        mreq.data = {16'd0, root_q};
      end
      default: begin
        unique case (sub_q)
          3'd0: begin mreq.coef = cfg_q[3]; mreq.data = hx_q; end
          3'd1: begin mreq.coef = cfg_q[4]; mreq.data = y1_q; end
          3'd2: begin mreq.coef = cfg_q[5]; mreq.data = y1_q; end
          3'd3: begin mreq.coef = cfg_q[6]; mreq.data = y2_q; end
          default: begin mreq.coef = cfg_q[7]; mreq.data = y2_q; end
        endcase
      end
    endcase
  end

  logic [63:0] trial;
  assign trial = {rem_q[61:0], sq_q[63:62]} - {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      for (int i = 0; i < NumRegs; i++) cfg_q[i] <= RegReset[i];
      phase_q  <= '0;
      for (int i = 0; i < 4; i++) lpd_q[i] <= '0;
      for (int i = 0; i < 8; i++) hpd_q[i] <= '0;
      ovalid_q <= 1'b0;
      mix_q <= '0; sub_q <= '0; ch_q <= 1'b0; it_q <= '0;
    end else begin
      if (psel && penable && pwrite)
        cfg_q[paddr[4:2]] <= pwdata;
      if (ovalid_q && m_axis_tready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid_i && s_axis_tready_o) begin
          x_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
          mix_q <= '0; sub_q <= '0; state_q <= S_LP;
        end
        S_LP: state_q <= S_LPW;
        S_LPW: if (mrsp.done) begin
          if (sub_q < 3'd2) begin
            state_q <= S_LP;
            sub_q <= sub_q + 3'd1;
          end
          unique case (sub_q)
            3'd0: y_q[mix_q] <= sat32(rnd + AccBits'(lpd_q[mix_q]));
            3'd1: t_q <= rnd;
            default: begin
              lpd_q[mix_q] <= sat32(t_q + rnd);
              sub_q <= '0;
              mix_q <= mix_q + 2'd1;
              if (mix_q == 2'd3) begin
                state_q <= S_SQ; ch_q <= 1'b0;
              end else begin
                state_q <= S_LP;
              end
            end
          endcase
        end
        S_SQ: begin
          sq_q <= 64'($signed(y_q[{ch_q,1'b0}][31:0]) * $signed(y_q[{ch_q,1'b0}][31:0]));
          state_q <= S_SQW;
        end
        S_SQW: begin
          sq_q <= sq_q + 64'($signed(y_q[{ch_q,1'b1}][31:0])
                              * $signed(y_q[{ch_q,1'b1}][31:0]));
          rem_q <= '0; root_q <= '0; it_q <= '0;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (!trial[63]) begin
            rem_q <= trial; root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q <= {rem_q[61:0], sq_q[63:62]}; root_q <= {root_q[30:0], 1'b0};
          end
          sq_q <= sq_q << 2;
          it_q <= it_q + 6'd1;
          if (it_q == 6'd31) state_q <= S_PI;
        end
        S_PI: state_q <= S_PIW;
        S_PIW: if (mrsp.done) begin
          if (((mrsp.prod + (AccBits'(1) <<< 34)) >>> 35) > AccBits'(24'hffffff))
            env_q[ch_q] <= 24'hffffff;
          else
            env_q[ch_q] <= 24'((mrsp.prod + (AccBits'(1) <<< 34)) >>> 35);
          if (ch_q) begin
            ch_q <= 1'b0; sub_q <= '0; state_q <= S_HP;
            hx_q <= 48'({1'b0, env_q[0]});
          end else begin
            ch_q <= 1'b1; state_q <= S_SQ;
          end
        end
        S_HP: state_q <= S_HPW;
        S_HPW: if (mrsp.done) begin
          if (sub_q < 3'd4) begin
            state_q <= S_HP;
            sub_q <= sub_q + 3'd1;
          end
          unique case (sub_q)
            3'd0: begin
              p_q  <= rnd[47:0];
              y1_q <= sat32(rnd + AccBits'(hpd_q[{ch_q,2'd0}]));
            end
            3'd1: hpd_q[{ch_q,2'd0}] <= sat32(AccBits'(-2) * AccBits'(p_q) + rnd
                                              + AccBits'(hpd_q[{ch_q,2'd1}]));
            3'd2: begin
              hpd_q[{ch_q,2'd1}] <= sat32(AccBits'(p_q) + rnd);
              y2_q <= sat32(AccBits'(y1_q) + AccBits'(hpd_q[{ch_q,2'd2}]));
            end
            3'd3: hpd_q[{ch_q,2'd2}] <= sat32(AccBits'(-2) * AccBits'(y1_q) + rnd
                                              + AccBits'(hpd_q[{ch_q,2'd3}]));
            default: begin
              hpd_q[{ch_q,2'd3}] <= sat32(AccBits'(y1_q) + rnd);
              sub_q <= '0;
              if (y2_q > 48'sd16777215) t_q <= AccBits'(25'h0ffffff);
              else if (y2_q < -48'sd16777216) t_q <= AccBits'(25'h1000000);
              else t_q <= AccBits'(y2_q[24:0]);
              if (ch_q) begin
                state_q <= S_OUT;
              end else begin
                state_q <= S_HP;
                amp1_q <= (y2_q > 48'sd16777215) ? 25'h0ffffff :
                          (y2_q < -48'sd16777216) ? 25'h1000000 : y2_q[24:0];
                ch_q <= 1'b1; hx_q <= 48'({1'b0, env_q[1]});
              end
            end
          endcase
        end
        default: if (!ovalid_q) begin
          out_q[23:0]   <= env_q[0];
          out_q[47:24]  <= env_q[1];
          out_q[72:48]  <= amp1_q;
          out_q[97:73]  <= t_q[24:0];
          out_q[103:98] <= '0;
          ovalid_q <= 1'b1;
          phase_q  <= (32'(phase_q) == REF_PERIOD-1) ? '0 : phase_q + PhBits'(1);
          state_q  <= S_IDLE;
        end
      endcase
    end
  end

endmodule
